[design/slid_pkg.sv]
// Package for the sorted list block: status codes, request kinds and the
// command struct that the top level broadcasts to every cell. No dependencies.
package slid_pkg;

  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  // Result status codes
  localparam logic [StatusW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatusW-1:0] ST_DELETED   = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Broadcast to all cells in the cycle of a transfer
  typedef struct packed {
    logic                     ins;    // apply an insert this cycle
    logic                     del;    // apply a delete this cycle
    logic signed [ValueW-1:0] value;  // value under test
  } cell_cmd_t;

endpackage

[design/sorted_list_insert_delete_top.sv]
// Top level of the sorted list: a chain of DEPTH slid_cell instances, the
// entry counter and the result register. Depends on slid_pkg and slid_cell.
//
//  channel | direction | tdata (low bit first)                    | tuser
//  --------+-----------+------------------------------------------+----------
//  s_*     | in        | value[31:0]                              | req_type
//  m_*     | out       | status[1:0], entry_count[6:2],           | -
//          |           | head_valid[7], head_value[39:8]          |
//
// One request is taken per cycle: every cell compares the broadcast value
// with its own entry in the cycle of the transfer and shifts at that edge.
// The result is shown on the next cycle; the count and head come straight
// from the counter and cell 0, which cannot change while a result waits.
// A stalled result holds s_tready low; it rises again in the cycle the
// result transfer completes, so back-to-back requests run at full rate.
// rst (synchronous) empties the list and drops any pending result.
module sorted_list_insert_delete_top import slid_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], entry_count[6:2],
                                 // head_valid[7], head_value[39:8]
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic                     accept;
  logic                     full;
  logic                     found;
  cell_cmd_t                cmd;
  logic [DEPTH-1:0]         after_vec;
  logic [DEPTH-1:0]         eq_vec;
  logic [DEPTH-1:0]         valid_vec;
  logic signed [ValueW-1:0] value_arr [DEPTH];

  logic [CntW-1:0]          count;
  logic [CntW+CountW-1:0]   count_ext;
  logic [StatusW-1:0]       status;
  logic [StatusW-1:0]       status_next;
  logic [ValueW-1:0]        head_value;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // List is full when the last cell holds a value; found when any cell matches
  assign full  = valid_vec[DEPTH-1];
  assign found = |eq_vec;

  assign cmd.ins   = accept && (s_tuser == REQ_INSERT) && !full;
  assign cmd.del   = accept && (s_tuser == REQ_DELETE) && found;
  assign cmd.value = s_tdata;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                     l_after;
      logic                     l_valid;
      logic signed [ValueW-1:0] l_value;
      logic                     r_valid;
      logic signed [ValueW-1:0] r_value;

      // Chain ends: left of cell 0 counts as a valid cell below the insert point,
      // right of the last cell as empty
      if (i == 0) begin : g_first
        assign l_after = 1'b0;
        assign l_valid = 1'b1;
        assign l_value = '0;
      end else begin : g_mid
        assign l_after = after_vec[i-1];
        assign l_valid = valid_vec[i-1];
        assign l_value = value_arr[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_value = '0;
      end else begin : g_inner
        assign r_valid = valid_vec[i+1];
        assign r_value = value_arr[i+1];
      end

      slid_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .left_after  (l_after),
        .left_valid  (l_valid),
        .left_value  (l_value),
        .right_valid (r_valid),
        .right_value (r_value),
        .after       (after_vec[i]),
        .eq          (eq_vec[i]),
        .valid       (valid_vec[i]),
        .value       (value_arr[i])
      );
    end
  endgenerate

  always_comb begin
    if (s_tuser == REQ_INSERT) begin
      status_next = full ? ST_FULL : ST_INSERTED;
    end else begin
      status_next = found ? ST_DELETED : ST_NOT_FOUND;
    end
  end

  // Advance the entry count with each applied insert or delete
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins) begin
      count <= count + 1'b1;
    end else if (cmd.del) begin
      count <= count - 1'b1;
    end
  end

  // Result register: hold until the downstream side takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // Report only the low bits of the count
  assign count_ext  = {{CountW{1'b0}}, count};
  assign head_value = valid_vec[0] ? value_arr[0] : '0;

  assign m_tdata = {head_value, valid_vec[0], count_ext[CountW-1:0], status};

endmodule

[design/slid_cell.sv]
// One cell of the sorted chain: holds one value and its valid bit, compares
// against the broadcast value and shifts towards either neighbour. Uses slid_pkg.
module slid_cell import slid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic                     left_after,
  input  logic                     left_valid,
  input  logic signed [ValueW-1:0] left_value,
  input  logic                     right_valid,
  input  logic signed [ValueW-1:0] right_value,
  output logic                     after,
  output logic                     eq,
  output logic                     valid,
  output logic signed [ValueW-1:0] value
);

  logic ge;

  // Stored values are ascending, so ge and after rise once along the chain
  assign ge    = valid && (value >= cmd.value);
  assign eq    = valid && (value == cmd.value);
  assign after = !valid || ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      valid <= left_valid;
    end else if (cmd.del && ge) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      // take the left neighbour above the insertion point, the new value at it
      if (left_after) begin
        value <= left_value;
      end else if (after) begin
        value <= cmd.value;
      end
    end else if (cmd.del && ge) begin
      value <= right_value;
    end
  end

endmodule
